// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by sm3_hash_engine_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication property checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication property.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/sm3_pkg.sv =====
// ---------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ---------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;
	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RUN,
		ST_OUT
	} state_t;

	localparam word_t T_LOW  = 32'h79cc4519;
	localparam word_t T_HIGH = 32'h7a879d8a;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	// Round unit control: start a block, step one round.
	typedef struct packed {
		logic start;
		logic step;
	} rnd_ctl_t;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage
`default_nettype wire

// ===== hdl/sm3_stream_if.sv =====
// ---------------------------------------------------------------------------
// sm3_in_if / sm3_out_if
// Valid/ready channels of the SM3 hash engine.
// ---------------------------------------------------------------------------
`default_nettype none
interface sm3_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic [2:0]  byte_count;
	logic        last;
	modport source (output valid, msg_word, byte_count, last, input ready);
	modport sink (input valid, msg_word, byte_count, last, output ready);
endinterface

interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        final_word;
	modport source (output valid, digest_word, final_word, input ready);
	modport sink (input valid, digest_word, final_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/sm3_round.sv =====
// ---------------------------------------------------------------------------
// sm3_round
// Compression round unit: 16-word sliding schedule window, A..H
// working registers, one round per step, chain XOR on the last round.
// ---------------------------------------------------------------------------
`default_nettype none
module sm3_round (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sm3_pkg::rnd_ctl_t ctl,
	input  wire logic [5:0]        rnd,
	input  wire sm3_pkg::word_t    blk [16],
	input  wire logic              chain_init,
	output sm3_pkg::word_t         chain [8]
);
	import sm3_pkg::*;

	word_t w_q [16];
	word_t v_q [8];
	word_t cv_q [8];
	word_t a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
	logic  lo;

	always_comb begin
		lo  = (rnd < 6'd16);
		tj  = lo ? T_LOW : T_HIGH;
		a12 = rotl(v_q[0], 5'd12);
		ss1 = rotl(a12 + v_q[4] + rotl(tj, rnd[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff  = lo ? (v_q[0] ^ v_q[1] ^ v_q[2]) :
			((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
		gg  = lo ? (v_q[4] ^ v_q[5] ^ v_q[6]) : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
		tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + v_q[7] + ss1 + w_q[0];
		// next schedule word W[j+16]
		wn  = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			w_q <= blk;
			v_q <= cv_q;
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[0] <= tt1;
			v_q[1] <= v_q[0];
			v_q[2] <= rotl(v_q[1], 5'd9);
			v_q[3] <= v_q[2];
			v_q[4] <= perm0(tt2);
			v_q[5] <= v_q[4];
			v_q[6] <= rotl(v_q[5], 5'd19);
			v_q[7] <= v_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= IV;
		end else if (chain_init) begin
			cv_q <= IV;
		end else if (ctl.step && rnd == 6'd63) begin
			cv_q[0] <= cv_q[0] ^ tt1;
			cv_q[1] <= cv_q[1] ^ v_q[0];
			cv_q[2] <= cv_q[2] ^ rotl(v_q[1], 5'd9);
			cv_q[3] <= cv_q[3] ^ v_q[2];
			cv_q[4] <= cv_q[4] ^ perm0(tt2);
			cv_q[5] <= cv_q[5] ^ v_q[4];
			cv_q[6] <= cv_q[6] ^ rotl(v_q[5], 5'd19);
			cv_q[7] <= cv_q[7] ^ v_q[6];
		end
	end

	assign chain = cv_q;
endmodule
`default_nettype wire

// ===== hdl/sm3_hash_engine_unit.sv =====
// Timing: a non-last word that fills no block leaves the input ready; a
// word that completes a 64-byte block holds the input until that block is
// compressed (one round a cycle). A last word pads a byte a cycle, pausing
// while a block compresses, with one or two compressions, then shows 8
// digest words, one per accepted output cycle.
// Reset: arst_n clears control, counters and chain value (SM3 IV) at once.
// ---------------------------------------------------------------------------
// sm3_hash_engine_unit
// SM3 hash engine top level: byte packer, pad sequencer and digest output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sm3_hash_engine_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	sm3_in_if.sink    in_ch,
	sm3_out_if.source out_ch
);
	import sm3_pkg::*;

	state_t      state_q, state_d;
	word_t       blk_q [16];
	logic [7:0]  spill_q [3]; // bytes past offset 63, held for the next block
	logic [5:0]  bib_q;       // bytes held in block
	logic [60:0] tot_q;       // message length in bytes
	logic [5:0]  rnd_q;
	logic        run_q;       // round unit busy (after load cycle)
	logic        pend_q;      // block full, compression needed
	logic        padded_q;    // 0x80 marker already placed
	logic        lenok_q;     // pad reached the block holding the length
	logic [2:0]  oidx_q;
	logic [2:0]  cnt;
	logic [2:0]  take;        // bytes to append this cycle
	logic [7:0]  bytes [4];
	logic [63:0] bits;
	logic [6:0]  sum;
	rnd_ctl_t    ctl;
	word_t       chain [8];
	logic        acc, fin;

	assign cnt  = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
	assign bits = {tot_q, 3'b000};

	// Input handshake only when idle and no compression waiting or running.
	assign in_ch.ready = (state_q == ST_IDLE) && !pend_q && !run_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.digest_word = chain[oidx_q];
	assign out_ch.final_word = (oidx_q == 3'd7);
	assign fin = out_ch.valid && out_ch.ready && oidx_q == 3'd7;

	// Pad sequencer: one byte per cycle when no block is pending or running;
	// length bytes at offset 56..63 of the block that padding reached below 56.
	always_comb begin
		state_d = state_q;
		take = 3'd0;
		for (int i = 0; i < 4; i++) bytes[i] = in_ch.msg_word[31-8*i -: 8];
		ctl.start = 1'b0;
		ctl.step = run_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					take = cnt;
					if (in_ch.last) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (!pend_q && !run_q) begin
					take = 3'd1;
					if (!padded_q) bytes[0] = PAD_BYTE;
					else if (lenok_q && bib_q >= 6'd56) bytes[0] = bits[8*(6'd63-bib_q) +: 8];
					else bytes[0] = 8'h00;
					if (padded_q && lenok_q && bib_q == 6'd63) state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!pend_q && !run_q) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (fin) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (pend_q && !run_q) ctl.start = 1'b1;
		sum = {1'b0, bib_q} + {4'd0, take};
	end

	// Byte packer: up to four bytes at once. Bytes of a word that run past
	// offset 63 are parked and land in word 0 of the next block on the load
	// cycle, at the same edge that copies the full block into the round unit.
	// Parked slots that were not used are overwritten by later bytes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < take) begin
				logic [6:0] p;
				p = {1'b0, bib_q} + 7'(i);
				if (p[6]) spill_q[p[1:0]] <= bytes[i];
				else blk_q[p[5:2]][8*(3-p[1:0]) +: 8] <= bytes[i];
			end
		end
		if (ctl.start) blk_q[0][31:8] <= {spill_q[0], spill_q[1], spill_q[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bib_q    <= '0;
			tot_q    <= '0;
			rnd_q    <= '0;
			run_q    <= 1'b0;
			pend_q   <= 1'b0;
			padded_q <= 1'b0;
			lenok_q  <= 1'b0;
			oidx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (fin) bib_q <= '0;
			else bib_q <= sum[5:0];
			if (sum[6] || (take != 3'd0 && sum[5:0] == 6'd0)) pend_q <= 1'b1;
			if (state_q == ST_IDLE && acc) tot_q <= tot_q + 61'(cnt);
			if (state_q == ST_PAD && take != 3'd0) padded_q <= 1'b1;
			if (state_q == ST_PAD && take != 3'd0 && bib_q < 6'd56) lenok_q <= 1'b1;
			if (ctl.start) begin
				pend_q <= 1'b0;
				run_q  <= 1'b1;
				rnd_q  <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) run_q <= 1'b0;
			end
			if (out_ch.valid && out_ch.ready) oidx_q <= oidx_q + 3'd1;
			if (fin) begin
				tot_q    <= '0;
				padded_q <= 1'b0;
				lenok_q  <= 1'b0;
			end
		end
	end

	sm3_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rnd        (rnd_q),
		.blk        (blk_q),
		.chain_init (fin),
		.chain      (chain)
	);

	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, run_q, !in_ch.ready, "input taken while compressing")
	`ASSERT_IMPL(a_out_idle, clk, arst_n, out_ch.valid, !run_q && !pend_q, "digest during compression")
	`ASSERT_NEXT(a_fin_idle, clk, arst_n, fin, state_q == ST_IDLE && oidx_q == 3'd0, "no return to idle")
endmodule
`default_nettype wire
